// ===== sv/pab_pkg.sv =====
// ----------------------------------------------------------------------------
// pab_pkg: shared types and constants for the pixel alpha blend stage
// Pixel and result beat layouts, op codes, register indexes, blend constants.
// ----------------------------------------------------------------------------
package pab_pkg;

	// op codes
	localparam logic [1:0] OP_ALPHA_TEST   = 2'd0;
	localparam logic [1:0] OP_ALPHA_DITHER = 2'd1;
	localparam logic [1:0] OP_BLEND        = 2'd2;
	localparam logic [1:0] OP_NO_WRITE     = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DITHER_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DITHER_HIGH = 2'd1;
	localparam int CFG_DATA_W = 64;

	// alpha limits
	localparam logic [7:0] OPAQUE_MIN = 8'd254;
	localparam logic [7:0] CLEAR_MAX  = 8'd1;
	localparam logic [7:0] FULL_SCALE = 8'd255;

	// divide by 255 with rounding: ((v + 127) * 0x8081) >> 23, exact for 16-bit input
	localparam logic [15:0] ROUND_BIAS  = 16'd127;
	localparam logic [15:0] RECIP_255   = 16'h8081;
	localparam int          RECIP_SHIFT = 23;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] x_phase;
		logic [1:0] y_phase;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_alpha;
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] dst_alpha;
	} pixel_t;

	typedef struct packed {
		logic       write_enable;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} result_t;

	// per-beat decision carried down the pipe
	typedef struct packed {
		logic pass_src;
		logic blend;
	} ctrl_t;

	typedef struct packed {
		ctrl_t      ctrl;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_alpha;
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] alpha_sum;
	} decode_t;

endpackage

// ===== sv/pixel_alpha_blend_stage.sv =====
// Throughput: one pixel per cycle unless result_stall holds the pipe; three
// register stages (decode, products, reciprocal divide and output select)
// each advance when the next has room.
// Reset clears all stage valid bits and both dither threshold words.
// ----------------------------------------------------------------------------
// pixel_alpha_blend_stage: raster output blend for 8-bit RGBA pixels
// Alpha test, ordered-dither alpha test and source-over blend with write mask.
// ----------------------------------------------------------------------------
module pixel_alpha_blend_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pab_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pab_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  pab_pkg::pixel_t                 pixel,
	output logic                            result_valid,
	input  logic                            result_stall,
	output pab_pkg::result_t                result
);

	logic             en1;
	logic             en2;
	logic             en3;
	logic             valid_s1;
	pab_pkg::decode_t dec_s1;
	logic             valid_s2;
	pab_pkg::ctrl_t   ctrl_s2;
	logic [7:0]       src_red_s2;
	logic [7:0]       src_green_s2;
	logic [7:0]       src_blue_s2;
	logic [7:0]       src_alpha_s2;
	logic [7:0]       alpha_sum_s2;
	logic [7:0]       quo_red;
	logic [7:0]       quo_green;
	logic [7:0]       quo_blue;
	logic             valid_s3;
	pab_pkg::result_t result_s3;
	pab_pkg::result_t res;

	// a stage moves when it is empty or the one after it moves
	assign en3 = !valid_s3 || !result_stall;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pixel_stall = !en1;

	pab_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.en          (en1),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.valid_s1    (valid_s1),
		.dec_s1      (dec_s1)
	);

	pab_mix u_mix_red (
		.clk   (clk),
		.en    (en2 && valid_s1),
		.dst   (dec_s1.dst_red),
		.src   (dec_s1.src_red),
		.alpha (dec_s1.src_alpha),
		.quo   (quo_red)
	);

	pab_mix u_mix_green (
		.clk   (clk),
		.en    (en2 && valid_s1),
		.dst   (dec_s1.dst_green),
		.src   (dec_s1.src_green),
		.alpha (dec_s1.src_alpha),
		.quo   (quo_green)
	);

	pab_mix u_mix_blue (
		.clk   (clk),
		.en    (en2 && valid_s1),
		.dst   (dec_s1.dst_blue),
		.src   (dec_s1.src_blue),
		.alpha (dec_s1.src_alpha),
		.quo   (quo_blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			ctrl_s2      <= dec_s1.ctrl;
			src_red_s2   <= dec_s1.src_red;
			src_green_s2 <= dec_s1.src_green;
			src_blue_s2  <= dec_s1.src_blue;
			src_alpha_s2 <= dec_s1.src_alpha;
			alpha_sum_s2 <= dec_s1.alpha_sum;
		end
	end

	always_comb begin
		res = '0;
		if (ctrl_s2.pass_src) begin
			res.write_enable = 1'b1;
			res.out_red      = src_red_s2;
			res.out_green    = src_green_s2;
			res.out_blue     = src_blue_s2;
			res.out_alpha    = src_alpha_s2;
		end else if (ctrl_s2.blend) begin
			res.write_enable = 1'b1;
			res.out_red      = quo_red;
			res.out_green    = quo_green;
			res.out_blue     = quo_blue;
			res.out_alpha    = alpha_sum_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			result_s3 <= res;
		end
	end

	assign result_valid = valid_s3;
	assign result       = result_s3;

endmodule

// ===== sv/pab_decode.sv =====
// ----------------------------------------------------------------------------
// pab_decode: threshold registers and first pipeline stage
// Holds the dither threshold words, picks the per-beat decision and the
// clamped alpha sum, and registers them with the source and destination.
// ----------------------------------------------------------------------------
module pab_decode (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pab_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pab_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            en,
	input  logic                            pixel_valid,
	input  pab_pkg::pixel_t                 pixel,
	output logic                            valid_s1,
	output pab_pkg::decode_t                dec_s1
);

	logic [pab_pkg::CFG_DATA_W-1:0] thr_low_q;
	logic [pab_pkg::CFG_DATA_W-1:0] thr_high_q;
	logic [pab_pkg::CFG_DATA_W-1:0] thr_word;
	logic [2:0]                     thr_idx;
	logic [7:0]                     threshold;
	logic [8:0]                     sum_wide;
	pab_pkg::ctrl_t                 ctrl;
	pab_pkg::decode_t               dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low_q  <= '0;
			thr_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pab_pkg::CFG_DITHER_LOW:  thr_low_q  <= cfg_data;
				pab_pkg::CFG_DITHER_HIGH: thr_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thr_word  = pixel.x_phase[1] ? thr_high_q : thr_low_q;
	assign thr_idx   = {pixel.x_phase[0], pixel.y_phase};
	assign threshold = thr_word[{thr_idx, 3'b000} +: 8];
	assign sum_wide  = {1'b0, pixel.dst_alpha} + {1'b0, pixel.src_alpha};

	always_comb begin
		ctrl = '0;
		unique case (pixel.op)
			pab_pkg::OP_ALPHA_TEST:   ctrl.pass_src = pixel.src_alpha >= pab_pkg::OPAQUE_MIN;
			pab_pkg::OP_ALPHA_DITHER: ctrl.pass_src = pixel.src_alpha >= threshold;
			pab_pkg::OP_BLEND: begin
				ctrl.pass_src = pixel.src_alpha >= pab_pkg::OPAQUE_MIN;
				ctrl.blend    = (pixel.src_alpha < pab_pkg::OPAQUE_MIN)
					&& (pixel.src_alpha > pab_pkg::CLEAR_MAX);
			end
			pab_pkg::OP_NO_WRITE: ;
			default: ;
		endcase
	end

	always_comb begin
		dec.ctrl      = ctrl;
		dec.src_red   = pixel.src_red;
		dec.src_green = pixel.src_green;
		dec.src_blue  = pixel.src_blue;
		dec.src_alpha = pixel.src_alpha;
		dec.dst_red   = pixel.dst_red;
		dec.dst_green = pixel.dst_green;
		dec.dst_blue  = pixel.dst_blue;
		dec.alpha_sum = sum_wide[8] ? pab_pkg::FULL_SCALE : sum_wide[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && pixel_valid) begin
			dec_s1 <= dec;
		end
	end

endmodule

// ===== sv/pab_mix.sv =====
// ----------------------------------------------------------------------------
// pab_mix: one colour channel of the blend
// Stage two registers dst*(255-a) + src*a + 127; the rounded divide by 255
// is a reciprocal multiply on that register, taken by the output stage.
// ----------------------------------------------------------------------------
module pab_mix (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] dst,
	input  logic [7:0] src,
	input  logic [7:0] alpha,
	output logic [7:0] quo
);

	logic [7:0]  inv_alpha;
	logic [15:0] dst_prod;
	logic [15:0] src_prod;
	logic [15:0] wsum_s2;
	logic [31:0] recip_prod;

	assign inv_alpha = pab_pkg::FULL_SCALE - alpha;
	assign dst_prod  = {8'd0, dst} * {8'd0, inv_alpha};
	assign src_prod  = {8'd0, src} * {8'd0, alpha};

	// sum stays below 2^16 since the two weights add to 255
	always_ff @(posedge clk) begin
		if (en) begin
			wsum_s2 <= dst_prod + src_prod + pab_pkg::ROUND_BIAS;
		end
	end

	assign recip_prod = {16'd0, wsum_s2} * {16'd0, pab_pkg::RECIP_255};
	assign quo        = recip_prod[pab_pkg::RECIP_SHIFT +: 8];

endmodule

// ===== sv/pab_checker.sv =====
// ----------------------------------------------------------------------------
// pab_checker: port-level checks for the pixel alpha blend stage
// Watches handshakes and result beats; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pab_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pixel_valid,
	input logic             pixel_stall,
	input logic             result_valid,
	input logic             result_stall,
	input pab_pkg::result_t result
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// no back-pressure on the input while the output drains
	a_no_stall_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !pixel_stall)
		else $error("pixel stalled while result side is open");

	// a beat that is not written carries zero colour
	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.write_enable |->
			result.out_red == 8'd0 && result.out_green == 8'd0
			&& result.out_blue == 8'd0 && result.out_alpha == 8'd0)
		else $error("masked result beat has nonzero colour");

	// an accepted beat reaches the result port when the output stays open
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("result beat missing after pipeline latency");

endmodule

bind pixel_alpha_blend_stage pab_checker u_pab_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_stall  (pixel_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== tb/sv/pixel_alpha_blend_stage_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_alpha_blend_stage_tb: self-checking bench for the alpha blend stage
// A queue of pixel beats feeds a clocked driver. Every accepted beat is run
// through a local blend predictor, and a clocked monitor checks each result
// beat against the oldest prediction. Dither thresholds change between phases.
// ----------------------------------------------------------------------------
module pixel_alpha_blend_stage_tb;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 5;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 64;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 200;

	// indexes past the register list, writes there must be dropped
	localparam logic [pab_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 2'd2;
	localparam logic [pab_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 2'd3;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            cfg_we       = 1'b0;
	logic [pab_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [pab_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                            pixel_valid  = 1'b0;
	logic                            pixel_stall;
	pab_pkg::pixel_t                 pixel        = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	pab_pkg::result_t                result;

	// local copy of the threshold words
	logic [63:0] dither_low  = '0;
	logic [63:0] dither_high = '0;

	pab_pkg::pixel_t  pixels_to_send[$];
	pab_pkg::result_t predicted_writes[$];
	pab_pkg::result_t due;

	int send_idle_pct = 9;
	int recv_idle_pct = 81;
	int mismatches    = 0;
	int results_seen  = 0;
	int cycle_count   = 0;
	bit hold_request  = 1'b0;
	bit hold_done     = 1'b0;
	int hold_left     = 0;

	pixel_alpha_blend_stage dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [7:0] dither_threshold(logic [1:0] x, logic [1:0] y);
		logic [63:0] word;
		logic [2:0]  slot;
		word = x[1] ? dither_high : dither_low;
		slot = {x[0], y};
		return word[slot*8 +: 8];
	endfunction

	function automatic logic [7:0] blend_channel(logic [7:0] dst, logic [7:0] src,
			logic [7:0] alpha);
		int unsigned weighted;
		weighted = int'(dst) * (255 - int'(alpha)) + int'(src) * int'(alpha);
		return 8'((weighted + 127) / 255);
	endfunction

	function automatic pab_pkg::result_t blend_pixel(pab_pkg::pixel_t p);
		pab_pkg::result_t r;
		logic             take_src;
		int unsigned      alpha_sum;
		r = '0;
		take_src = 1'b0;
		case (p.op)
			pab_pkg::OP_ALPHA_TEST: begin
				take_src = p.src_alpha >= pab_pkg::OPAQUE_MIN;
			end
			pab_pkg::OP_ALPHA_DITHER: begin
				take_src = p.src_alpha >= dither_threshold(p.x_phase, p.y_phase);
			end
			pab_pkg::OP_BLEND: begin
				if (p.src_alpha >= pab_pkg::OPAQUE_MIN) begin
					take_src = 1'b1;
				end else if (p.src_alpha > pab_pkg::CLEAR_MAX) begin
					alpha_sum      = int'(p.dst_alpha) + int'(p.src_alpha);
					r.write_enable = 1'b1;
					r.out_red      = blend_channel(p.dst_red, p.src_red, p.src_alpha);
					r.out_green    = blend_channel(p.dst_green, p.src_green, p.src_alpha);
					r.out_blue     = blend_channel(p.dst_blue, p.src_blue, p.src_alpha);
					r.out_alpha    = (alpha_sum > 255) ? 8'd255 : 8'(alpha_sum);
				end
			end
			default: begin
			end
		endcase
		if (take_src) begin
			r.write_enable = 1'b1;
			r.out_red      = p.src_red;
			r.out_green    = p.src_green;
			r.out_blue     = p.src_blue;
			r.out_alpha    = p.src_alpha;
		end
		return r;
	endfunction

	function automatic pab_pkg::pixel_t make_pixel(logic [1:0] op, logic [1:0] x,
			logic [1:0] y, logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] sa,
			logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] da);
		pab_pkg::pixel_t p;
		p.op        = op;
		p.x_phase   = x;
		p.y_phase   = y;
		p.src_red   = sr;
		p.src_green = sg;
		p.src_blue  = sb;
		p.src_alpha = sa;
		p.dst_red   = dr;
		p.dst_green = dg;
		p.dst_blue  = db;
		p.dst_alpha = da;
		return p;
	endfunction

	// colour byte, now and then pinned to an end of the range
	function automatic logic [7:0] random_channel();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pab_pkg::pixel_t random_pixel();
		pab_pkg::pixel_t p;
		logic [7:0]      t;
		p.op        = 2'($urandom_range(3));
		p.x_phase   = 2'($urandom_range(3));
		p.y_phase   = 2'($urandom_range(3));
		p.src_red   = random_channel();
		p.src_green = random_channel();
		p.src_blue  = random_channel();
		p.dst_red   = random_channel();
		p.dst_green = random_channel();
		p.dst_blue  = random_channel();
		p.dst_alpha = random_channel();
		t = dither_threshold(p.x_phase, p.y_phase);
		case ($urandom_range(9))
			4, 5: begin
				// the alpha limits of test and blend
				case ($urandom_range(5))
					0: p.src_alpha = 8'd0;
					1: p.src_alpha = pab_pkg::CLEAR_MAX;
					2: p.src_alpha = 8'd2;
					3: p.src_alpha = 8'd253;
					4: p.src_alpha = pab_pkg::OPAQUE_MIN;
					default: p.src_alpha = pab_pkg::FULL_SCALE;
				endcase
			end
			6, 7: begin
				// right around the dither threshold of this cell
				p.src_alpha = t + 8'($urandom_range(2)) - 8'd1;
			end
			default: begin
				p.src_alpha = 8'($urandom);
			end
		endcase
		return p;
	endfunction

	task automatic write_register(logic [pab_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pab_pkg::CFG_DITHER_LOW) begin
			dither_low = value;
		end else if (idx == pab_pkg::CFG_DITHER_HIGH) begin
			dither_high = value;
		end
	endtask

	task automatic wait_drained();
		while (pixels_to_send.size() != 0 || pixel_valid || predicted_writes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		repeat (count) pixels_to_send.push_back(random_pixel());
	endtask

	// thresholds are set so that cells hold 0, 1, 0xfe and 0xff among others
	task automatic queue_directed();
		// alpha test around the opaque limit
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_TEST, 2'd0, 2'd0,
			8'h12, 8'h34, 8'h56, 8'd254, 8'hff, 8'hff, 8'hff, 8'hff));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_TEST, 2'd1, 2'd1,
			8'hff, 8'hff, 8'hff, 8'd253, 8'h00, 8'h00, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_TEST, 2'd2, 2'd2,
			8'hff, 8'h00, 8'hff, 8'd255, 8'h00, 8'hff, 8'h00, 8'hff));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_TEST, 2'd3, 2'd3,
			8'hff, 8'hff, 8'hff, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff));
		// ordered dither at zero, one, 0xfe and 0xff thresholds
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd1, 2'd2,
			8'h01, 8'h02, 8'h03, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd1, 2'd3,
			8'haa, 8'h55, 8'haa, 8'd254, 8'h00, 8'h00, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd1, 2'd3,
			8'h55, 8'haa, 8'h55, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd3, 2'd2,
			8'hff, 8'hff, 8'hff, 8'd254, 8'hff, 8'hff, 8'hff, 8'hff));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd3, 2'd3,
			8'h80, 8'h40, 8'h20, 8'd0, 8'h11, 8'h22, 8'h33, 8'h44));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd2, 2'd1,
			8'h10, 8'h20, 8'h30, 8'hfd, 8'h00, 8'h00, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd2, 2'd1,
			8'h10, 8'h20, 8'h30, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_ALPHA_DITHER, 2'd0, 2'd0,
			8'hff, 8'hff, 8'hff, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff));
		// blend: opaque, transparent, partial with extremes and alpha clamp
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd0, 2'd1,
			8'h9a, 8'hbc, 8'hde, 8'd254, 8'h01, 8'h02, 8'h03, 8'h04));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd2, 2'd3,
			8'h9a, 8'hbc, 8'hde, 8'd255, 8'h01, 8'h02, 8'h03, 8'h04));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd3, 2'd0,
			8'hff, 8'hff, 8'hff, 8'd1, 8'h10, 8'h20, 8'h30, 8'h40));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd3, 2'd1,
			8'hff, 8'hff, 8'hff, 8'd0, 8'h10, 8'h20, 8'h30, 8'h40));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd0, 2'd2,
			8'hff, 8'h00, 8'hff, 8'd2, 8'h00, 8'hff, 8'h00, 8'h00));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd1, 2'd0,
			8'hff, 8'h00, 8'h80, 8'd253, 8'h00, 8'hff, 8'h7f, 8'hff));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd2, 2'd0,
			8'hff, 8'hff, 8'hff, 8'd128, 8'h00, 8'h00, 8'h00, 8'd200));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd0, 2'd3,
			8'h00, 8'h00, 8'h00, 8'd127, 8'hff, 8'hff, 8'hff, 8'd128));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_BLEND, 2'd2, 2'd2,
			8'hff, 8'hff, 8'hff, 8'd253, 8'hff, 8'hff, 8'hff, 8'hff));
		// no write mode, even with an opaque source
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_NO_WRITE, 2'd3, 2'd3,
			8'hff, 8'hff, 8'hff, 8'd255, 8'hff, 8'hff, 8'hff, 8'hff));
		pixels_to_send.push_back(make_pixel(pab_pkg::OP_NO_WRITE, 2'd0, 2'd0,
			8'h00, 8'h00, 8'h00, 8'd128, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// driver: predicts on acceptance, then offers the next queued beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				predicted_writes.push_back(blend_pixel(pixel));
			end
			if (!pixel_valid || !pixel_stall) begin
				if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pixel_valid <= 1'b1;
					pixel       <= pixels_to_send.pop_front();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, so the pipe fills and backs up into the input
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen <= results_seen + 1;
			if (predicted_writes.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < MAX_REPORTS) begin
					$display("result %0d arrived with nothing predicted: ",
						"we=%0b rgba=%0d,%0d,%0d,%0d",
						results_seen, result.write_enable, result.out_red, result.out_green,
						result.out_blue, result.out_alpha);
				end
			end else begin
				due = predicted_writes.pop_front();
				if (result.write_enable !== due.write_enable || result.out_red !== due.out_red
						|| result.out_green !== due.out_green || result.out_blue !== due.out_blue
						|| result.out_alpha !== due.out_alpha) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS) begin
						$display("result %0d: expected we=%0b rgba=%0d,%0d,%0d,%0d ",
							results_seen, due.write_enable, due.out_red, due.out_green,
							due.out_blue, due.out_alpha,
							"got we=%0b rgba=%0d,%0d,%0d,%0d", result.write_enable,
							result.out_red, result.out_green, result.out_blue,
							result.out_alpha);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(pab_pkg::CFG_DITHER_LOW, 64'hff00_8180_7f7e_0201);
		write_register(pab_pkg::CFG_DITHER_HIGH, 64'h00ff_10ef_c040_fe01);
		queue_directed();
		wait_drained();

		// every threshold at full scale
		write_register(pab_pkg::CFG_DITHER_LOW, '1);
		write_register(pab_pkg::CFG_DITHER_HIGH, '1);
		queue_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 81;
		recv_idle_pct = 9;
		write_register(pab_pkg::CFG_DITHER_LOW, '0);
		write_register(pab_pkg::CFG_DITHER_HIGH, '0);
		queue_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(pab_pkg::CFG_DITHER_LOW, {$urandom, $urandom});
		write_register(pab_pkg::CFG_DITHER_HIGH, {$urandom, $urandom});
		write_register(CFG_UNMAPPED_A, {$urandom, $urandom});
		write_register(CFG_UNMAPPED_B, {$urandom, $urandom});
		queue_random(PHASE_ITEMS);
		hold_request = 1'b1;
		wait_drained();

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pab_pkg.sv
sv/pab_decode.sv
sv/pab_mix.sv
sv/pixel_alpha_blend_stage.sv
sv/pab_checker.sv
tb/sv/pixel_alpha_blend_stage_tb.sv
